FILE: hw/rtl/quadratic_root_solver_unit_defines.svh
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion shorthands; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs: implication check failed");
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs: next-cycle check failed");
`else
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Fixed codes and widths shared by the solver files.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CNT_W = 2;
  localparam int TOL_W = 16;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_INF  = 2'd3;

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DBL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TWO  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUAD = 3'd5;

  localparam int CFG_AW = 3;
  localparam logic REG_IDX_ZERO_TOL = 1'b0;
  localparam logic [TOL_W-1:0] ZERO_TOL_RESET = 16'd1;

endpackage

FILE: hw/rtl/qrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver channels
// Valid/ready word channels for coefficient sets and root results.
// ----------------------------------------------------------------------------
interface qrs_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] coef_a;
  logic [DATA_WIDTH-1:0] coef_b;
  logic [DATA_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                        valid;
  logic                        ready;
  logic [qrs_pkg::CNT_W-1:0]   root_count;
  logic [DATA_WIDTH-1:0]       root_one;
  logic [DATA_WIDTH-1:0]       root_two;
  logic                        overflow;

  modport source (output valid, root_count, root_one, root_two, overflow, input ready);
  modport sink (input valid, root_count, root_one, root_two, overflow, output ready);
endinterface

FILE: hw/rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of a bitwise integer square root: resolves one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int ROOT_W = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [2*ROOT_W-1:0]   dat_i,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [2*ROOT_W-1:0]   dat_o
);

  localparam int CUR_W = ROOT_W + 4;

  logic [CUR_W-1:0]    cur;
  logic [CUR_W-1:0]    trial;
  logic [CUR_W-1:0]    diff;
  logic                ge;
  logic [ROOT_W+1:0]   rem_nxt;
  logic [ROOT_W-1:0]   root_nxt;
  logic [2*ROOT_W-1:0] dat_nxt;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [2*ROOT_W-1:0] dat_r;

  always_comb begin
    cur      = {rem_i, dat_i[2*ROOT_W-1 -: 2]};
    trial    = CUR_W'({root_i, 2'b01});
    diff     = cur - trial;
    ge       = (cur >= trial);
    rem_nxt  = ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    dat_nxt  = {dat_i[2*ROOT_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      dat_r  <= dat_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign dat_o  = dat_r;

endmodule

FILE: hw/rtl/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for two dividends that share a divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int DEN_W = 33,
  parameter int QUO_W = 51
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [1:0][DEN_W-1:0]  rem_i,
  input  logic [1:0][QUO_W-1:0]  quo_i,
  input  logic [1:0][QUO_W-1:0]  dat_i,
  output logic [DEN_W-1:0]       den_o,
  output logic [1:0][DEN_W-1:0]  rem_o,
  output logic [1:0][QUO_W-1:0]  quo_o,
  output logic [1:0][QUO_W-1:0]  dat_o
);

  logic [1:0][DEN_W:0]   cur;
  logic [1:0][DEN_W:0]   diff;
  logic [1:0]            ge;
  logic [1:0][DEN_W-1:0] rem_nxt;
  logic [1:0][QUO_W-1:0] quo_nxt;
  logic [1:0][QUO_W-1:0] dat_nxt;
  logic [DEN_W-1:0]      den_r;
  logic [1:0][DEN_W-1:0] rem_r;
  logic [1:0][QUO_W-1:0] quo_r;
  logic [1:0][QUO_W-1:0] dat_r;

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      cur[ln]     = {rem_i[ln], dat_i[ln][QUO_W-1]};
      diff[ln]    = cur[ln] - {1'b0, den_i};
      ge[ln]      = (cur[ln] >= {1'b0, den_i});
      rem_nxt[ln] = ge[ln] ? diff[ln][DEN_W-1:0] : cur[ln][DEN_W-1:0];
      quo_nxt[ln] = {quo_i[ln][QUO_W-2:0], ge[ln]};
      dat_nxt[ln] = {dat_i[ln][QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dat_r <= dat_nxt;
    end
  end

  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dat_o = dat_r;

endmodule

FILE: hw/rtl/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The block accepts one coefficient word per clock unless the output stalls and
// returns one result word per coefficient word, in order. The pipeline holds
// registers for the coefficients, for the zero tests and the products and for
// the discriminant, a row of DATA_WIDTH+1 square-root cells that each settle
// one root bit, a numerator register, a row of DATA_WIDTH+FRAC_BITS+3 divider
// cells that each settle one quotient bit of both roots, and the output
// register. The whole pipeline advances together; it moves whenever the
// output register is empty or being read, so the sustained rate is one word
// per cycle. A coefficient whose magnitude is below zero_tolerance (register
// 0, byte address 0) counts as zero, and so does a discriminant below
// zero_tolerance scaled by 2^FRAC_BITS. Roots that do not fit are clamped and
// flagged; unused root fields read zero.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  qrs_in_if.sink                      in_ch,
  qrs_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qrs_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 1;                    // discriminant magnitude
  localparam int CW   = (DW > qrs_pkg::TOL_W + F) ? DW : qrs_pkg::TOL_W + F;
  localparam int SW   = (DW + 1) / 2;                 // square root width
  localparam int NW   = W + 3;                        // signed numerator width
  localparam int DENW = W + 1;                        // divisor magnitude width
  localparam int QW   = NW + F;                       // quotient width
  localparam int MW   = qrs_pkg::MODE_W;

  typedef struct packed {
    logic          vld;
    logic [MW-1:0] mode;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  c;
  } sq_side_t;

  typedef struct packed {
    logic          vld;
    logic [MW-1:0] mode;
    logic          neg1;
    logic          neg2;
  } dv_side_t;

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  logic [qrs_pkg::TOL_W-1:0] tol_r;
  logic                      cfg_hit;

  assign cfg_hit = (paddr[qrs_pkg::CFG_AW-1] == qrs_pkg::REG_IDX_ZERO_TOL);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? 32'(tol_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrs_pkg::ZERO_TOL_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      tol_r <= pwdata[qrs_pkg::TOL_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: every stage moves when the output register can take a word.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: capture the coefficients.
  logic         v1_r;
  logic [W-1:0] a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= in_ch.coef_a;
      b1_r <= in_ch.coef_b;
      c1_r <= in_ch.coef_c;
    end
  end

  // Stage 1 to 2: magnitudes, zero tests and the two products.
  logic [W-1:0]   ma, mb, mc;
  logic           za, zb, zc;
  logic [MW-1:0]  mode1;

  always_comb begin
    ma = a1_r[W-1] ? (W'(0) - a1_r) : a1_r;
    mb = b1_r[W-1] ? (W'(0) - b1_r) : b1_r;
    mc = c1_r[W-1] ? (W'(0) - c1_r) : c1_r;
    // An exact zero is zero even when the tolerance is zero.
    za = (a1_r == '0) || (ma < W'(tol_r));
    zb = (b1_r == '0) || (mb < W'(tol_r));
    zc = (c1_r == '0) || (mc < W'(tol_r));
    if (!za) begin
      mode1 = qrs_pkg::MODE_QUAD;
    end else if (!zb) begin
      mode1 = qrs_pkg::MODE_LIN;
    end else if (zc) begin
      mode1 = qrs_pkg::MODE_INF;
    end else begin
      mode1 = qrs_pkg::MODE_NONE;
    end
  end

  logic           v2_r;
  logic [MW-1:0]  mode2_r;
  logic [W-1:0]   a2_r, b2_r, c2_r;
  logic           sdiff2_r;
  logic [2*W-1:0] bb2_r, ac2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2_r  <= mode1;
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      c2_r     <= c1_r;
      sdiff2_r <= a1_r[W-1] ^ c1_r[W-1];
      bb2_r    <= (2*W)'(mb) * (2*W)'(mb);
      ac2_r    <= (2*W)'(ma) * (2*W)'(mc);
    end
  end

  // Stage 2 to 3: discriminant magnitude and sign, b^2 - 4ac.
  logic [DW-1:0] bbx, ac4, dm2;
  logic [DW:0]   dsub;
  logic          dneg2;

  always_comb begin
    bbx  = DW'(bb2_r);
    ac4  = DW'({ac2_r, 2'b00});
    dsub = {1'b0, bbx} - {1'b0, ac4};
    if (sdiff2_r) begin
      dm2   = bbx + ac4;
      dneg2 = 1'b0;
    end else if (!dsub[DW]) begin
      dm2   = dsub[DW-1:0];
      dneg2 = 1'b0;
    end else begin
      dm2   = ac4 - bbx;
      dneg2 = 1'b1;
    end
  end

  logic          v3_r;
  logic [MW-1:0] mode3_r;
  logic [W-1:0]  a3_r, b3_r, c3_r;
  logic [DW-1:0] dm3_r;
  logic          dneg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode3_r <= mode2_r;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      c3_r    <= c2_r;
      dm3_r   <= dm2;
      dneg3_r <= dneg2;
    end
  end

  // Stage 3: classify the quadratic case. A tiny discriminant of either sign
  // gives the double root.
  logic          dsmall;
  logic [MW-1:0] mode3;

  always_comb begin
    dsmall = (dm3_r == '0) ||
             (CW'(dm3_r) < CW'({tol_r, {F{1'b0}}}));
    mode3  = mode3_r;
    if (mode3_r == qrs_pkg::MODE_QUAD) begin
      if (dsmall) begin
        mode3 = qrs_pkg::MODE_DBL;
      end else if (dneg3_r) begin
        mode3 = qrs_pkg::MODE_NONE;
      end else begin
        mode3 = qrs_pkg::MODE_TWO;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root row: one root bit per cell, two radicand bits consumed each.
  // --------------------------------------------------------------------------
  logic [SW+1:0]   sq_rem  [0:SW];
  logic [SW-1:0]   sq_root [0:SW];
  logic [2*SW-1:0] sq_dat  [0:SW];
  sq_side_t        sq_sb   [0:SW];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_dat[0]  = (2*SW)'(dm3_r);
  assign sq_sb[0]   = '{vld: v3_r, mode: mode3, a: a3_r, b: b3_r, c: c3_r};

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    sq_side_t sb_r;

    qrs_sqrt_cell #(.ROOT_W(SW)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .dat_i  (sq_dat[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .dat_o  (sq_dat[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r.vld <= 1'b0;
      end else if (adv) begin
        sb_r <= sq_sb[k];
      end
    end

    assign sq_sb[k+1] = sb_r;
  end

  // --------------------------------------------------------------------------
  // Numerators: -c/b if linear, -b/(2a) if double, (-b +- s)/(2a) if two roots.
  // --------------------------------------------------------------------------
  sq_side_t      sqo;
  logic [NW-1:0] bneg, cneg, sx, n1, n2, n1m, n2m;
  logic [DENW-1:0] den, denm;

  assign sqo = sq_sb[SW];

  always_comb begin
    bneg = NW'(0) - {{(NW-W){sqo.b[W-1]}}, sqo.b};
    cneg = NW'(0) - {{(NW-W){sqo.c[W-1]}}, sqo.c};
    sx   = NW'(sq_root[SW]);
    case (sqo.mode)
      qrs_pkg::MODE_LIN: begin
        n1  = cneg;
        n2  = '0;
        den = {sqo.b[W-1], sqo.b};
      end
      qrs_pkg::MODE_DBL: begin
        n1  = bneg;
        n2  = '0;
        den = {sqo.a, 1'b0};
      end
      qrs_pkg::MODE_TWO: begin
        n1  = bneg + sx;
        n2  = bneg - sx;
        den = {sqo.a, 1'b0};
      end
      default: begin
        // No division needed; a divisor of one keeps the row well defined.
        n1  = '0;
        n2  = '0;
        den = DENW'(1);
      end
    endcase
    n1m  = n1[NW-1] ? (NW'(0) - n1) : n1;
    n2m  = n2[NW-1] ? (NW'(0) - n2) : n2;
    denm = den[DENW-1] ? (DENW'(0) - den) : den;
  end

  logic            v5_r;
  logic [MW-1:0]   mode5_r;
  logic            neg1_5_r, neg2_5_r;
  logic [NW-1:0]   n1m5_r, n2m5_r;
  logic [DENW-1:0] den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= sqo.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode5_r  <= sqo.mode;
      neg1_5_r <= n1[NW-1] ^ den[DENW-1];
      neg2_5_r <= n2[NW-1] ^ den[DENW-1];
      n1m5_r   <= n1m;
      n2m5_r   <= n2m;
      den5_r   <= denm;
    end
  end

  // --------------------------------------------------------------------------
  // Divider row: both roots share the divisor, one quotient bit per cell.
  // --------------------------------------------------------------------------
  logic [DENW-1:0]         dv_den [0:QW];
  logic [1:0][DENW-1:0]    dv_rem [0:QW];
  logic [1:0][QW-1:0]      dv_quo [0:QW];
  logic [1:0][QW-1:0]      dv_dat [0:QW];
  dv_side_t                dv_sb  [0:QW];

  assign dv_den[0] = den5_r;
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;
  assign dv_dat[0] = {{n2m5_r, {F{1'b0}}}, {n1m5_r, {F{1'b0}}}};
  assign dv_sb[0]  = '{vld: v5_r, mode: mode5_r, neg1: neg1_5_r, neg2: neg2_5_r};

  for (genvar k = 0; k < QW; k++) begin : g_div
    dv_side_t sb_r;

    qrs_div_cell #(.DEN_W(DENW), .QUO_W(QW)) u_cell (
      .clk   (clk),
      .en    (adv),
      .den_i (dv_den[k]),
      .rem_i (dv_rem[k]),
      .quo_i (dv_quo[k]),
      .dat_i (dv_dat[k]),
      .den_o (dv_den[k+1]),
      .rem_o (dv_rem[k+1]),
      .quo_o (dv_quo[k+1]),
      .dat_o (dv_dat[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r.vld <= 1'b0;
      end else if (adv) begin
        sb_r <= dv_sb[k];
      end
    end

    assign dv_sb[k+1] = sb_r;
  end

  // --------------------------------------------------------------------------
  // Saturation, sign and field selection into the output register.
  // --------------------------------------------------------------------------
  dv_side_t           dvo;
  logic [1:0][QW-1:0] lim;
  logic [1:0]         over;
  logic [1:0]         negs;
  logic [1:0][W-1:0]  rmag, rval;
  logic [qrs_pkg::CNT_W-1:0] cnt_nxt;
  logic [W-1:0]       r1_nxt, r2_nxt;
  logic               ovf_nxt;

  assign dvo  = dv_sb[QW];
  assign negs = {dvo.neg2, dvo.neg1};

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      // Largest magnitude: 2^(W-1) for a negative root, one less otherwise.
      lim[ln]  = QW'({1'b1, {(W-1){1'b0}}}) - QW'(!negs[ln]);
      over[ln] = (dv_quo[QW][ln] > lim[ln]);
      rmag[ln] = over[ln] ? lim[ln][W-1:0] : dv_quo[QW][ln][W-1:0];
      rval[ln] = negs[ln] ? (W'(0) - rmag[ln]) : rmag[ln];
    end
    case (dvo.mode) inside
      qrs_pkg::MODE_LIN, qrs_pkg::MODE_DBL: begin
        cnt_nxt = qrs_pkg::CNT_ONE;
        r1_nxt  = rval[0];
        r2_nxt  = '0;
        ovf_nxt = over[0];
      end
      qrs_pkg::MODE_TWO: begin
        cnt_nxt = qrs_pkg::CNT_TWO;
        r1_nxt  = rval[0];
        r2_nxt  = rval[1];
        ovf_nxt = over[0] || over[1];
      end
      qrs_pkg::MODE_INF: begin
        cnt_nxt = qrs_pkg::CNT_INF;
        r1_nxt  = '0;
        r2_nxt  = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
        cnt_nxt = qrs_pkg::CNT_NONE;
        r1_nxt  = '0;
        r2_nxt  = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  logic [qrs_pkg::CNT_W-1:0] cnt_r;
  logic [W-1:0]              r1_r, r2_r;
  logic                      ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dvo.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt_r <= cnt_nxt;
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.root_count = cnt_r;
  assign out_ch.root_one   = r1_r;
  assign out_ch.root_two   = r2_r;
  assign out_ch.overflow   = ovf_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `QRS_ASSERT_IMP(a_inf_fields_zero, clk, rst_n,
    out_valid_r && (cnt_r == qrs_pkg::CNT_INF || cnt_r == qrs_pkg::CNT_NONE),
    r1_r == '0 && r2_r == '0 && !ovf_r)
  `QRS_ASSERT_IMP(a_ovf_needs_root, clk, rst_n,
    out_valid_r && ovf_r,
    cnt_r == qrs_pkg::CNT_ONE || cnt_r == qrs_pkg::CNT_TWO)
  `QRS_ASSERT_NXT(a_stall_freezes_rows, clk, rst_n,
    !adv,
    $stable(v5_r) && $stable(dvo.vld) && $stable(sqo.vld))

endmodule
